>>> rtl/ucfs_pkg.sv
// Shared types and constants for the serial command framer with link session.
`timescale 1ns / 1ps

package ucfs_pkg;

	localparam int IBT_W      = 16;  // inter-byte timeout register
	localparam int STO_W      = 20;  // session timeout register
	localparam int GAP_W      = 17;  // inter-byte gap timer
	localparam int SESS_W     = 21;  // session idle timer
	localparam int CMD_W      = 48;  // emitted command field
	localparam int ACC_W      = 64;  // assembly word, room for the widest command
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 20;

	localparam logic [IBT_W-1:0]  IBT_RESET  = IBT_W'(200);
	localparam logic [STO_W-1:0]  STO_RESET  = STO_W'(30000);
	localparam logic [GAP_W-1:0]  GAP_MAX    = '1;
	localparam logic [SESS_W-1:0] SESS_MAX   = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INTER_BYTE_TIMEOUT = 2'd0,
		REG_SESSION_TIMEOUT    = 2'd1
	} cfg_reg_t;

	typedef enum logic {
		OP_TICK = 1'b0,
		OP_BYTE = 1'b1
	} op_t;

	typedef struct packed {
		logic       operation;
		logic [7:0] rx_byte;
		logic       radio_link_up;
	} item_t;

	typedef struct packed {
		logic             command_valid;
		logic [CMD_W-1:0] command_bytes;
		logic             stop_advertising;
		logic             restart_advertising;
		logic             session_active;
	} result_t;

	typedef struct packed {
		logic [IBT_W-1:0] inter_byte_timeout_ms;
		logic [STO_W-1:0] session_timeout_ms;
	} cfg_t;

endpackage

>>> rtl/uart_command_framer_with_session.sv
// Top level: serial command framer with link session and advertising control.
//
//   channel  | handshake           | payload
//   ---------+---------------------+--------------------------------------------------
//   in       | in_valid / in_stall | operation, rx_byte, radio_link_up
//   out      | out_valid/out_stall | command_valid, command_bytes, stop_advertising,
//            |                     | restart_advertising, session_active
//   cfg      | cfg_wr_en           | cfg_index, cfg_wdata
//
// One item per clock sustained while the output does not stall; the transfer loads the input
// register, and when the result register can take the item, the combinational state update
// is loaded into the result register, raising out_valid; the result leaves when out_stall is low.
// Reset restores both timeouts, clears the byte count, timers and session flag.
// An output stall holds the result register; the input stalls only when the input
// register is full and the result register cannot take its item.
`timescale 1ns / 1ps

module uart_command_framer_with_session #(
	parameter int CMD_BYTES = 6
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            operation,
	input  logic [7:0]                      rx_byte,
	input  logic                            radio_link_up,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            command_valid,
	output logic [ucfs_pkg::CMD_W-1:0]      command_bytes,
	output logic                            stop_advertising,
	output logic                            restart_advertising,
	output logic                            session_active,
	input  logic                            cfg_wr_en,
	input  logic [ucfs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ucfs_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import ucfs_pkg::*;

	cfg_t    cfg;
	item_t   in_item;
	item_t   item_s1;
	result_t result;
	result_t result_q;
	logic    fire;
	logic    out_free;

	assign in_item.operation     = operation;
	assign in_item.rx_byte       = rx_byte;
	assign in_item.radio_link_up = radio_link_up;

	ucfs_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	ucfs_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.out_free (out_free),
		.fire     (fire),
		.item_s1  (item_s1)
	);

	ucfs_core #(
		.CMD_BYTES (CMD_BYTES)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.item_s1 (item_s1),
		.cfg     (cfg),
		.result  (result)
	);

	ucfs_out_stage u_out_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.result    (result),
		.out_free  (out_free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.result_q  (result_q)
	);

	assign command_valid       = result_q.command_valid;
	assign command_bytes       = result_q.command_bytes;
	assign stop_advertising    = result_q.stop_advertising;
	assign restart_advertising = result_q.restart_advertising;
	assign session_active      = result_q.session_active;

endmodule

>>> rtl/ucfs_cfg_regs.sv
// Configuration registers for the timeouts.
`timescale 1ns / 1ps

module ucfs_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [ucfs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ucfs_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output ucfs_pkg::cfg_t                 cfg
);
	import ucfs_pkg::*;

	logic [IBT_W-1:0] ibt_q;
	logic [STO_W-1:0] sto_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ibt_q <= IBT_RESET;
			sto_q <= STO_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_INTER_BYTE_TIMEOUT: ibt_q <= cfg_wdata[IBT_W-1:0];
				REG_SESSION_TIMEOUT:    sto_q <= cfg_wdata[STO_W-1:0];
				default: ;  // unmapped index, write dropped
			endcase
		end
	end

	assign cfg.inter_byte_timeout_ms = ibt_q;
	assign cfg.session_timeout_ms    = sto_q;

endmodule

>>> rtl/ucfs_in_stage.sv
// Input register stage with its valid/stall handshake.
`timescale 1ns / 1ps

module ucfs_in_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  ucfs_pkg::item_t in_item,
	input  logic            out_free,
	output logic            fire,
	output ucfs_pkg::item_t item_s1
);
	import ucfs_pkg::*;

	logic valid_s1;
	logic accept;

	// item in the stage moves on whenever the result register can take it
	assign fire     = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_item;
		end
	end

endmodule

>>> rtl/ucfs_core.sv
// Framer and session state with the combinational update per item, registered on each transfer.
`timescale 1ns / 1ps

module ucfs_core #(
	parameter int CMD_BYTES = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  ucfs_pkg::item_t   item_s1,
	input  ucfs_pkg::cfg_t    cfg,
	output ucfs_pkg::result_t result
);
	import ucfs_pkg::*;

	localparam int CNT_W = $clog2(CMD_BYTES + 1);
	localparam int IDX_W = (CMD_BYTES > 1) ? $clog2(CMD_BYTES) : 1;
	localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(CMD_BYTES - 1);

	logic [7:0]        byte_store_q [CMD_BYTES];
	logic [CNT_W-1:0]  count_q;
	logic [GAP_W-1:0]  gap_q;
	logic              flag_q;
	logic [SESS_W-1:0] sess_q;

	logic [CNT_W-1:0]  count_n;
	logic [CNT_W-1:0]  cnt0;
	logic [GAP_W-1:0]  gap_n;
	logic              flag_n;
	logic [SESS_W-1:0] sess_n;
	logic              tick;
	logic              gap_expired;
	logic              store_we;
	logic [IDX_W-1:0]  wr_idx;
	logic [ACC_W-1:0]  acc;

	assign tick = (item_s1.operation == OP_TICK);

	always_comb begin
		gap_n  = gap_q;
		sess_n = sess_q;
		if (tick && gap_q != GAP_MAX) begin
			gap_n = gap_q + 1'b1;
		end
		if (tick && sess_q != SESS_MAX) begin
			sess_n = sess_q + 1'b1;
		end

		gap_expired = (count_q != '0) && (gap_n > {1'b0, cfg.inter_byte_timeout_ms});
		cnt0        = gap_expired ? '0 : count_q;
		wr_idx      = cnt0[IDX_W-1:0];
		count_n     = count_q;
		flag_n      = flag_q;
		store_we    = 1'b0;
		result      = '0;

		if (item_s1.radio_link_up) begin
			flag_n  = 1'b0;
			count_n = '0;
		end else if (!tick) begin
			store_we = 1'b1;
			gap_n    = '0;
			if (cnt0 == LAST_IDX) begin
				result.stop_advertising = !flag_q;
				result.command_valid    = 1'b1;
				flag_n  = 1'b1;
				sess_n  = '0;
				count_n = '0;
			end else begin
				count_n = cnt0 + 1'b1;
			end
		end else begin
			count_n = cnt0;
			if (flag_q && sess_n > {1'b0, cfg.session_timeout_ms}) begin
				flag_n = 1'b0;
				result.restart_advertising = 1'b1;
			end
		end

		// last byte comes straight from the item, the rest from the store
		acc = '0;
		for (int i = 0; i < CMD_BYTES; i++) begin
			acc = {acc[ACC_W-9:0], (i == CMD_BYTES - 1) ? item_s1.rx_byte : byte_store_q[i]};
		end
		if (result.command_valid) begin
			result.command_bytes = acc[CMD_W-1:0];
		end
		result.session_active = flag_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			gap_q   <= '0;
			flag_q  <= 1'b0;
			sess_q  <= '0;
		end else if (fire) begin
			count_q <= count_n;
			gap_q   <= gap_n;
			flag_q  <= flag_n;
			sess_q  <= sess_n;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && store_we) begin
			byte_store_q[wr_idx] <= item_s1.rx_byte;
		end
	end

endmodule

>>> rtl/ucfs_out_stage.sv
// Result register on the output channel.
`timescale 1ns / 1ps

module ucfs_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  ucfs_pkg::result_t result,
	output logic              out_free,
	output logic              out_valid,
	input  logic              out_stall,
	output ucfs_pkg::result_t result_q
);
	import ucfs_pkg::*;

	logic out_valid_q;

	// free when empty or when the held result leaves this cycle
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_q <= result;
		end
	end

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the serial command framer with link session.
`timescale 1ns / 1ps

module tb_top;
	import ucfs_pkg::*;

	localparam int CMD_LEN        = 6;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int RANDOM_PHASES  = 8;
	localparam int PHASE_ITEMS    = 156;
	localparam int SILENCE_TICKS  = 40;
	// register slots the block does not decode
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic                  operation = 1'b0;
	logic [7:0]            rx_byte = 8'h00;
	logic                  radio_link_up = 1'b0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  command_valid;
	logic [CMD_W-1:0]      command_bytes;
	logic                  stop_advertising;
	logic                  restart_advertising;
	logic                  session_active;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	// framer state as predicted
	logic [7:0]       pend_bytes [CMD_LEN];
	logic [2:0]       pend_count = '0;
	logic [GAP_W-1:0] gap_ms = '0;
	logic [SESS_W-1:0] session_ms = '0;
	logic             session_open = 1'b0;
	logic [IBT_W-1:0] ibt_ms = IBT_RESET;
	logic [STO_W-1:0] session_limit_ms = STO_RESET;

	result_t cmd_expected_q [$];
	int      mismatch_count = 0;
	int      items_sent = 0;
	int      idle_cycles = 0;
	bit      gaps_on = 1'b1;
	bit      stalls_on = 1'b1;

	uart_command_framer_with_session u_dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.in_valid            (in_valid),
		.in_stall            (in_stall),
		.operation           (operation),
		.rx_byte             (rx_byte),
		.radio_link_up       (radio_link_up),
		.out_valid           (out_valid),
		.out_stall           (out_stall),
		.command_valid       (command_valid),
		.command_bytes       (command_bytes),
		.stop_advertising    (stop_advertising),
		.restart_advertising (restart_advertising),
		.session_active      (session_active),
		.cfg_wr_en           (cfg_wr_en),
		.cfg_index           (cfg_index),
		.cfg_wdata           (cfg_wdata)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Advance the predicted framer by one item and queue what it should emit.
	task automatic frame_item(input op_t op, input logic [7:0] b, input logic link);
		result_t r;
		r = '0;
		if (op == OP_TICK) begin
			if (gap_ms != GAP_MAX)
				gap_ms = gap_ms + 1'b1;
			if (session_ms != SESS_MAX)
				session_ms = session_ms + 1'b1;
		end
		if (link) begin
			session_open = 1'b0;
			pend_count = '0;
		end else if (op == OP_BYTE) begin
			if (pend_count != 0 && gap_ms > ibt_ms)
				pend_count = '0;
			pend_bytes[pend_count] = b;
			pend_count = pend_count + 1'b1;
			gap_ms = '0;
			if (pend_count == CMD_LEN) begin
				if (!session_open) begin
					session_open = 1'b1;
					r.stop_advertising = 1'b1;
				end
				session_ms = '0;
				r.command_valid = 1'b1;
				for (int i = 0; i < CMD_LEN; i++)
					r.command_bytes = {r.command_bytes[CMD_W-9:0], pend_bytes[i]};
				pend_count = '0;
			end
		end else begin
			if (pend_count != 0 && gap_ms > ibt_ms)
				pend_count = '0;
			if (session_open && session_ms > session_limit_ms) begin
				session_open = 1'b0;
				r.restart_advertising = 1'b1;
			end
		end
		r.session_active = session_open;
		cmd_expected_q.push_back(r);
	endtask

	// Present one item and hold it until the transfer; valid stays high on return.
	task automatic send_item(input op_t op, input logic [7:0] b, input logic link);
		while (gaps_on && $urandom_range(0, 99) < 31) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		rx_byte <= b;
		radio_link_up <= link;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		frame_item(op, b, link);
		items_sent++;
	endtask

	task automatic send_ticks(input int n, input logic link);
		for (int i = 0; i < n; i++)
			send_item(OP_TICK, 8'($urandom), link);
	endtask

	// Six bytes with in-window tick gaps between them.
	task automatic send_command(input int max_gap);
		for (int i = 0; i < CMD_LEN; i++) begin
			if (i != 0)
				send_ticks($urandom_range(0, max_gap), 1'b0);
			send_item(OP_BYTE, 8'($urandom), 1'b0);
		end
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (cmd_expected_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic program_timeouts(input logic [CFG_DATA_W-1:0] ibt_word,
			input logic [CFG_DATA_W-1:0] sto_word, input bit with_spare);
		drain_results();
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_INTER_BYTE_TIMEOUT;
		cfg_wdata <= ibt_word;
		@(posedge clk);
		if (with_spare) begin
			cfg_index <= REG_SPARE_A;
			cfg_wdata <= CFG_DATA_W'($urandom);
			@(posedge clk);
			cfg_index <= REG_SPARE_B;
			cfg_wdata <= CFG_DATA_W'($urandom);
			@(posedge clk);
		end
		cfg_index <= REG_SESSION_TIMEOUT;
		cfg_wdata <= sto_word;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		ibt_ms = ibt_word[IBT_W-1:0];
		session_limit_ms = sto_word[STO_W-1:0];
	endtask

	// Reset timeouts: commands with extreme bytes, session open, link drop.
	task automatic test_directed_session();
		send_item(OP_TICK, 8'h00, 1'b0);
		send_item(OP_BYTE, 8'h00, 1'b0);
		send_item(OP_BYTE, 8'hFF, 1'b0);
		send_item(OP_BYTE, 8'hA5, 1'b0);
		send_item(OP_TICK, 8'hFF, 1'b0);
		send_item(OP_BYTE, 8'h5A, 1'b0);
		send_item(OP_BYTE, 8'h01, 1'b0);
		send_item(OP_BYTE, 8'h80, 1'b0);
		for (int i = 0; i < CMD_LEN; i++)
			send_item(OP_BYTE, 8'hFF, 1'b0);
		send_item(OP_BYTE, 8'h3C, 1'b1);
		send_item(OP_TICK, 8'hC3, 1'b1);
	endtask

	// Partial command dropped on a late tick, then a session that times out.
	task automatic test_gap_and_session_timeouts();
		program_timeouts(CFG_DATA_W'(1), CFG_DATA_W'(2), 1'b0);
		send_item(OP_BYTE, 8'h11, 1'b0);
		send_ticks(2, 1'b0);
		for (int i = 0; i < CMD_LEN; i++)
			send_item(OP_BYTE, 8'(8'h20 + i), 1'b0);
		send_ticks(3, 1'b0);
	endtask

	// Widest windows keep a partial command across a run of ticks, back to back.
	task automatic test_long_silence();
		program_timeouts({4'hF, 16'hFFFF}, 20'hFFFFF, 1'b0);
		gaps_on = 1'b0;
		stalls_on = 1'b0;
		send_item(OP_BYTE, 8'hE7, 1'b0);
		send_ticks(SILENCE_TICKS, 1'b0);
		for (int i = 0; i < CMD_LEN; i++)
			send_item(OP_BYTE, 8'($urandom), 1'b0);
		drain_results();
		gaps_on = 1'b1;
		stalls_on = 1'b1;
	endtask

	task automatic test_random_traffic();
		int phase_end;
		int kind;
		int n;
		int gap_lim;
		logic [CFG_DATA_W-1:0] ibt_word;
		logic [CFG_DATA_W-1:0] sto_word;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: begin
					ibt_word = '0;
					sto_word = CFG_DATA_W'(1);
				end
				1: begin
					ibt_word = {4'hA, 16'hFFFF};
					sto_word = 20'hFFFFF;
				end
				default: begin
					ibt_word = {4'($urandom), 16'($urandom_range(0, 12))};
					sto_word = CFG_DATA_W'($urandom_range(0, 40));
				end
			endcase
			program_timeouts(ibt_word, sto_word, phase == 2);
			// one phase runs back to back with no gaps or stalls
			gaps_on = (phase != 3);
			stalls_on = (phase != 3);
			gap_lim = (ibt_ms < 4) ? int'(ibt_ms) : 4;
			phase_end = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end) begin
				kind = $urandom_range(0, 99);
				if (kind < 60) begin
					send_command(gap_lim);
				end else if (kind < 75) begin
					n = (session_limit_ms > 30) ? 30 : int'(session_limit_ms) + 3;
					send_ticks($urandom_range(1, n), 1'b0);
				end else if (kind < 85) begin
					// broken command: a few bytes, then maybe a long pause
					n = $urandom_range(1, CMD_LEN - 1);
					for (int i = 0; i < n; i++)
						send_item(OP_BYTE, 8'($urandom), 1'b0);
					send_ticks($urandom_range(0, gap_lim + 3), 1'b0);
				end else if (kind < 92) begin
					n = $urandom_range(1, 4);
					for (int i = 0; i < n; i++)
						send_item(op_t'($urandom_range(0, 1)), 8'($urandom), 1'b1);
				end else begin
					send_item(op_t'($urandom_range(0, 1)), 8'($urandom),
						$urandom_range(0, 9) == 0);
				end
			end
		end
		gaps_on = 1'b1;
		stalls_on = 1'b1;
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_session();
		test_gap_and_session_timeouts();
		test_long_silence();
		test_random_traffic();
		drain_results();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && cmd_expected_q.size() == 0)
			$display("uart_command_framer_with_session test passed");
		else
			$display("uart_command_framer_with_session test failed");
		$finish;
	end

	always @(posedge clk) begin
		out_stall <= stalls_on && ($urandom_range(0, 99) < 31);
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (cmd_expected_q.size() == 0) begin
				$error("result transfer with nothing expected");
				mismatch_count++;
			end else begin
				want = cmd_expected_q.pop_front();
				if (command_valid !== want.command_valid) begin
					$error("command_valid: expected %0d, got %0d",
						want.command_valid, command_valid);
					mismatch_count++;
				end
				if (command_bytes !== want.command_bytes) begin
					$error("command_bytes: expected %h, got %h",
						want.command_bytes, command_bytes);
					mismatch_count++;
				end
				if (stop_advertising !== want.stop_advertising) begin
					$error("stop_advertising: expected %0d, got %0d",
						want.stop_advertising, stop_advertising);
					mismatch_count++;
				end
				if (restart_advertising !== want.restart_advertising) begin
					$error("restart_advertising: expected %0d, got %0d",
						want.restart_advertising, restart_advertising);
					mismatch_count++;
				end
				if (session_active !== want.session_active) begin
					$error("session_active: expected %0d, got %0d",
						want.session_active, session_active);
					mismatch_count++;
				end
			end
		end
	end

	// cycles without any transfer on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
				if (idle_cycles >= WATCHDOG_LIMIT) begin
					$display("uart_command_framer_with_session test failed");
					$finish;
				end
			end
		end
	end

endmodule

>>> sim.f
rtl/ucfs_pkg.sv
rtl/ucfs_cfg_regs.sv
rtl/ucfs_in_stage.sv
rtl/ucfs_core.sv
rtl/ucfs_out_stage.sv
rtl/uart_command_framer_with_session.sv
tb/tb_top.sv
